/* sv/repeated_kmer_detector_unit_macros.svh */
// Assertion macros for the repeated k-mer detector checker.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef REPEATED_KMER_DETECTOR_UNIT_MACROS_SVH
`define REPEATED_KMER_DETECTOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RKD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("repeated kmer detector assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RKD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("repeated kmer detector assertion failed");

`endif

/* sv/rkd_pkg.sv */
// Shared types and constants of the repeated k-mer detector.
// Used by rkd_out_fifo, repeated_kmer_detector_unit and rkd_checker; depends on nothing.
package rkd_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned OUT_W      = 20;
  localparam int unsigned CNT_W      = 2;
  localparam int unsigned FIFO_DEPTH = 3;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;

  localparam logic [1:0] CODE_A     = 2'd0;
  localparam logic [1:0] CODE_T     = 2'd1;
  localparam logic [1:0] CODE_G     = 2'd2;
  localparam logic [1:0] CODE_OTHER = 2'd3;

  typedef logic [CNT_W-1:0] count_t;

  localparam count_t CNT_ZERO = 2'd0;
  localparam count_t CNT_SAT  = 2'd2;

  typedef enum logic {
    ST_RUN,
    ST_SWEEP
  } state_e;

  typedef struct packed {
    logic [OUT_W-1:0] key;
    logic [OUT_W-1:0] start;
  } result_t;

  function automatic logic [1:0] base_code(input logic [CHAR_W-1:0] ch);
    logic [1:0] code;
    unique case (ch)
      CHAR_A:  code = CODE_A;
      CHAR_T:  code = CODE_T;
      CHAR_G:  code = CODE_G;
      default: code = CODE_OTHER;
    endcase
    return code;
  endfunction

endpackage

/* sv/rkd_out_fifo.sv */
// Three-entry result queue between the count pipeline and the output channel.
// Depends on rkd_pkg for the result type and depth.
module rkd_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rkd_pkg::result_t data_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output rkd_pkg::result_t data_o,
  output logic [1:0]       count_o
);

  rkd_pkg::result_t ent_q [rkd_pkg::FIFO_DEPTH];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign data_o      = ent_q[rd_ptr_q];
  assign count_o     = cnt_q;
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == 2'(rkd_pkg::FIFO_DEPTH - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == 2'(rkd_pkg::FIFO_DEPTH - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* sv/repeated_kmer_detector_unit.sv */
// Repeated k-mer detector: one character per cycle while in_stall_o is low.
// Throughput is one item per cycle unless stalled, set by one count memory read and write.
// A result queue of three entries lets input continue while the output is stalled.
// After reset, and before a first-flagged item once the store holds counts, a clearing
// pass writes 4^WINDOW_LEN entries (1048576 by default) and input is stalled.
// Depends on rkd_pkg and rkd_out_fifo.
module repeated_kmer_detector_unit #(
  parameter int unsigned WINDOW_LEN = 10,
  parameter int unsigned POS_BITS   = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [rkd_pkg::CHAR_W-1:0] base_char_i,
  input  logic                     first_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [rkd_pkg::OUT_W-1:0] window_key_o,
  output logic [rkd_pkg::OUT_W-1:0] start_position_o
);

  localparam int unsigned KeyBits = 2 * WINDOW_LEN;
  localparam int unsigned FillW   = $clog2(WINDOW_LEN + 1);
  localparam longint unsigned MemDepth = 64'd1 << KeyBits;

  rkd_pkg::state_e state_q, state_d;
  logic [KeyBits-1:0]  sw_q, sw_d;
  logic [KeyBits-1:0]  win_q, win_d, win_base;
  logic [FillW-1:0]    fill_q, fill_d, fill_base;
  logic [POS_BITS-1:0] pos_q, pos_d, pos_base;
  logic                dirty_q, dirty_d;
  logic                sweeping, sweep_done;
  logic                accept, full;
  logic [POS_BITS-1:0] start_pos;

  rkd_pkg::count_t     mem [MemDepth];
  rkd_pkg::count_t     rdata_q;
  logic                mem_we;
  logic [KeyBits-1:0]  mem_waddr;
  rkd_pkg::count_t     mem_wdata;

  logic                s1_v_q;
  logic [KeyBits-1:0]  s1_key_q;
  logic [POS_BITS-1:0] s1_start_q;
  logic                fwd_v_q;
  logic [KeyBits-1:0]  fwd_key_q;
  rkd_pkg::count_t     fwd_cnt_q;
  rkd_pkg::count_t     cnt_cur, cnt_inc, cnt_upd;
  logic                bump, push;
  logic [1:0]          fifo_cnt;
  logic                queue_full;
  rkd_pkg::result_t    push_data, out_data;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rkd_pkg::ST_RUN: begin
        if (in_valid_i && first_i && dirty_q) begin
          state_d = rkd_pkg::ST_SWEEP;
        end
      end
      rkd_pkg::ST_SWEEP: begin
        if (sw_q == '1) begin
          state_d = rkd_pkg::ST_RUN;
        end
      end
      default: state_d = rkd_pkg::ST_RUN;
    endcase
  end

  // State outputs.
  always_comb begin
    sweeping   = 1'b0;
    sweep_done = 1'b0;
    unique case (state_q)
      rkd_pkg::ST_RUN: begin
        sweeping = 1'b0;
      end
      rkd_pkg::ST_SWEEP: begin
        sweeping   = 1'b1;
        sweep_done = (sw_q == '1);
      end
      default: sweeping = 1'b0;
    endcase
  end

  assign queue_full = (3'(fifo_cnt) + 3'(s1_v_q)) >= 3'(rkd_pkg::FIFO_DEPTH);
  assign in_stall_o = sweeping || (first_i && dirty_q) || queue_full;
  assign accept     = in_valid_i && !in_stall_o;

  // Window update for the accepted character.
  always_comb begin
    win_base  = first_i ? '0 : win_q;
    fill_base = first_i ? '0 : fill_q;
    pos_base  = first_i ? '0 : pos_q;
    win_d     = win_q;
    fill_d    = fill_q;
    pos_d     = pos_q;
    if (accept) begin
      win_d  = KeyBits'({win_base, rkd_pkg::base_code(base_char_i)});
      fill_d = (fill_base < FillW'(WINDOW_LEN)) ? fill_base + FillW'(1) : fill_base;
      pos_d  = (pos_base != '1) ? pos_base + POS_BITS'(1) : pos_base;
    end
    full      = accept && (fill_d == FillW'(WINDOW_LEN));
    start_pos = (pos_base == '1) ? pos_base : pos_base - POS_BITS'(WINDOW_LEN - 1);
  end

  assign sw_d    = sweeping ? sw_q + KeyBits'(1) : sw_q;
  assign dirty_d = sweep_done ? 1'b0 : (dirty_q || full);

  // Read-modify-write of the count, with the previous cycle's write forwarded.
  always_comb begin
    cnt_cur = (fwd_v_q && (fwd_key_q == s1_key_q)) ? fwd_cnt_q : rdata_q;
    cnt_inc = cnt_cur + rkd_pkg::count_t'(1);
    bump    = s1_v_q && (cnt_cur < rkd_pkg::CNT_SAT);
    cnt_upd = bump ? cnt_inc : cnt_cur;
    push    = bump && (cnt_inc == rkd_pkg::CNT_SAT);
    if (sweeping) begin
      mem_we    = 1'b1;
      mem_waddr = sw_q;
      mem_wdata = rkd_pkg::CNT_ZERO;
    end else begin
      mem_we    = bump;
      mem_waddr = s1_key_q;
      mem_wdata = cnt_inc;
    end
    push_data.key   = rkd_pkg::OUT_W'(s1_key_q);
    push_data.start = rkd_pkg::OUT_W'(s1_start_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rkd_pkg::ST_SWEEP;
      sw_q    <= '0;
      win_q   <= '0;
      fill_q  <= '0;
      pos_q   <= '0;
      dirty_q <= 1'b0;
      s1_v_q  <= 1'b0;
      fwd_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sw_q    <= sw_d;
      win_q   <= win_d;
      fill_q  <= fill_d;
      pos_q   <= pos_d;
      dirty_q <= dirty_d;
      s1_v_q  <= full;
      fwd_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (full) begin
      s1_key_q   <= win_d;
      s1_start_q <= start_pos;
    end
    if (s1_v_q) begin
      fwd_key_q <= s1_key_q;
      fwd_cnt_q <= cnt_upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (full) begin
      rdata_q <= mem[win_d];
    end
  end

  rkd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (push_data),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .data_o      (out_data),
    .count_o     (fifo_cnt)
  );

  assign window_key_o     = out_data.key;
  assign start_position_o = out_data.start;

endmodule

/* sv/rkd_checker.sv */
// Port-level checker for the repeated k-mer detector, bound to the top level.
// Depends on repeated_kmer_detector_unit_macros.svh and rkd_pkg.
`include "repeated_kmer_detector_unit_macros.svh"

module rkd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [rkd_pkg::OUT_W-1:0]   window_key_o
);

  // A stalled result stays offered.
  `RKD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result keeps its key.
  `RKD_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(window_key_o))

  // A new result always follows an input transfer, through the count stage and the result queue.
  `RKD_ASSERT_NOW(a_out_latency, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 2))

  // The clearing pass after reset holds off input.
  `RKD_ASSERT_NOW(a_reset_sweep, $rose(rst_ni), in_stall_o)

endmodule

bind repeated_kmer_detector_unit rkd_checker u_rkd_checker (.*);
